// ----- rtl/stt_pkg.sv -----
// Shared types and constants for the sleep timer table.
`timescale 1ns / 1ps

package stt_pkg;

    // Field widths fixed by the interface.
    localparam int OWNER_W = 8;
    localparam int TICKS_W = 32;
    localparam int MS_W    = 24;
    localparam int RATE_W  = 14;
    localparam int KIND_W  = 2;

    // Millisecond to tick conversion. Since 1000 = 8 * 125, a value below 2**24
    // divided by 1000 is (value >> 3) * RECIP_125 >> 28, with RECIP_125 the
    // ceiling of 2**28 / 125; the rounding error stays below one quotient step.
    localparam int MS_PER_S  = 1000;
    localparam int REM_W     = $clog2(MS_PER_S);
    localparam int QMS_W     = 15;
    localparam int ARATE_W   = QMS_W + RATE_W;
    localparam int PRE_SH    = 3;
    localparam int RECIP_W   = 22;
    localparam int RECIP_SH  = 28;
    localparam int DPROD_W   = MS_W - PRE_SH + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_125 = 22'd2147484;

    // At most this many releases are reported for one tick.
    localparam int MAX_RESULTS = 16;
    localparam int NREL_W      = $clog2(MAX_RESULTS + 1);

    // Operation codes of an input word.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL    = 2'd2;

    // One table entry.
    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [TICKS_W-1:0] ticks;
    } t_entry;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic load;   // write a new owner and count
        logic shift;  // take the right neighbor's entry
        logic dec;    // count down by one, stopping at zero
    } t_cell_ctl;

endpackage

// ----- rtl/sleep_timer_table_top.sv -----
// Top level of the sleep timer table: sequencer, tick converter and row of cells.
`timescale 1ns / 1ps
//
// Use: a word is taken when start is high and busy is low. With i_op set, the
// word sets or refreshes the timer of i_owner_id to i_delay_ms milliseconds,
// converted to ticks with the tick rate register; one result follows, kind set
// or full, with o_last high. The accepting edge loads the tick converter; when
// the converter signals done, the result register is loaded, so the result is on
// the ports as busy drops. With i_op clear, the word is one tick: the sequencer
// walks the stored entries one per cycle, then ends the walk and flushes the
// held release, after which busy drops. Each expired owner comes out as a
// release result; the final one carries o_last, and a tick with nothing expired
// gives no result. Results are shown for one cycle under o_strobe and cannot be
// held off. The tick rate is written through i_cfg_valid and i_cfg_data; the
// user must do so only while busy is low, and the block does not enforce this.
// Reset empties the table and sets the rate to 18.
//
module sleep_timer_table_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_op,
    input  logic [stt_pkg::OWNER_W-1:0] i_owner_id,
    input  logic [stt_pkg::MS_W-1:0]    i_delay_ms,
    output logic                        o_strobe,
    output logic [stt_pkg::KIND_W-1:0]  o_kind,
    output logic [stt_pkg::OWNER_W-1:0] o_owner_out,
    output logic                        o_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [stt_pkg::RATE_W-1:0]  i_cfg_data
);
    import stt_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SET   = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]         r_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_left;
    logic [IW-1:0]      r_w;
    logic [NREL_W-1:0]  r_nrel;
    logic               r_pend;
    logic [OWNER_W-1:0] r_pend_owner;
    logic [OWNER_W-1:0] r_owner_req;
    logic [RATE_W-1:0]  r_rate;
    logic               r_strobe;
    logic [KIND_W-1:0]  r_kind;
    logic [OWNER_W-1:0] r_owner_out;
    logic               r_last;

    logic               w_accept;
    logic               w_div_done;
    logic [TICKS_W-1:0] w_ticks;
    t_entry             w_load_data;
    t_entry             w_entry [MAX_ENTRIES];
    logic               w_exp   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] w_hit;
    logic               w_any_hit;
    logic               w_full;
    logic               w_walk;
    logic               w_rel;
    logic               w_keep;
    logic               w_set_wr;

    assign busy        = (r_state != ST_IDLE);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    // Tick conversion unit.
    stt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && (i_op == OP_SET)),
        .i_ms    (i_delay_ms),
        .i_rate  (r_rate),
        .o_done  (w_div_done),
        .o_ticks (w_ticks)
    );

    assign w_load_data.owner = r_owner_req;
    assign w_load_data.ticks = w_ticks;

    // Walk decisions on the entry at the write position.
    assign w_walk   = (r_state == ST_WALK) && (r_left != '0);
    assign w_rel    = w_walk && w_exp[r_w] && (r_nrel < NREL_W'(MAX_RESULTS));
    assign w_keep   = w_walk && !w_rel;
    assign w_any_hit = |w_hit;
    assign w_full   = (r_count >= CW'(MAX_ENTRIES));
    assign w_set_wr = (r_state == ST_SET) && w_div_done;

    // The row of cells; the last cell has no right neighbor and keeps its own.
    for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
        t_cell_ctl w_ctl;
        t_entry    w_next;
        logic      w_match;

        assign w_hit[gi] = w_match && (CW'(gi) < r_count);

        always_comb begin
            w_ctl.load  = w_set_wr &&
                          (w_any_hit ? w_hit[gi] : (!w_full && (CW'(gi) == r_count)));
            w_ctl.shift = w_rel && (IW'(gi) >= r_w);
            w_ctl.dec   = w_keep && (IW'(gi) == r_w);
        end

        if (gi == MAX_ENTRIES - 1) begin : g_tail
            assign w_next = w_entry[gi];
        end else begin : g_body
            assign w_next = w_entry[gi + 1];
        end

        stt_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_next      (w_next),
            .i_load_data (w_load_data),
            .i_owner_req (r_owner_req),
            .o_entry     (w_entry[gi]),
            .o_expired   (w_exp[gi]),
            .o_match     (w_match)
        );
    end

    // Tick rate register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_W'(18);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_rate <= i_cfg_data;
        end
    end

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_w      <= '0;
            r_nrel   <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_op == OP_SET) begin
                            r_state <= ST_SET;
                        end else begin
                            r_state <= ST_WALK;
                            r_left  <= r_count;
                            r_w     <= '0;
                            r_nrel  <= '0;
                            r_pend  <= 1'b0;
                        end
                    end
                end
                ST_SET: begin
                    if (w_div_done) begin
                        r_strobe <= 1'b1;
                        r_last   <= 1'b1;
                        if (w_any_hit) begin
                            r_kind <= KIND_SET;
                        end else if (w_full) begin
                            r_kind <= KIND_FULL;
                        end else begin
                            r_kind  <= KIND_SET;
                            r_count <= r_count + CW'(1);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_WALK: begin
                    if (r_left == '0) begin
                        r_state <= ST_FLUSH;
                    end else begin
                        r_left <= r_left - CW'(1);
                        if (w_rel) begin
                            // Hold each release back one step to learn whether it is the last.
                            r_count      <= r_count - CW'(1);
                            r_nrel       <= r_nrel + NREL_W'(1);
                            r_pend       <= 1'b1;
                            r_pend_owner <= w_entry[r_w].owner;
                            if (r_pend) begin
                                r_strobe <= 1'b1;
                                r_kind   <= KIND_RELEASE;
                                r_last   <= 1'b0;
                            end
                        end else begin
                            r_w <= IW'(r_w + IW'(1));
                        end
                    end
                end
                ST_FLUSH: begin
                    if (r_pend) begin
                        r_strobe <= 1'b1;
                        r_kind   <= KIND_RELEASE;
                        r_last   <= 1'b1;
                    end
                    r_pend  <= 1'b0;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Owner field of the result: the request owner, or the held release.
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_op == OP_SET)) begin
            r_owner_req <= i_owner_id;
        end
        if (w_set_wr) begin
            r_owner_out <= r_owner_req;
        end else if ((w_rel && r_pend) || ((r_state == ST_FLUSH) && r_pend)) begin
            r_owner_out <= r_pend_owner;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_kind      = r_kind;
    assign o_owner_out = r_owner_out;
    assign o_last      = r_last;

endmodule

// ----- rtl/stt_cell.sv -----
// One cell of the timer row: holds one entry and hands it to its left neighbor.
`timescale 1ns / 1ps

module stt_cell (
    input  logic                      i_clk,
    input  stt_pkg::t_cell_ctl        i_ctl,
    input  stt_pkg::t_entry           i_next,
    input  stt_pkg::t_entry           i_load_data,
    input  logic [stt_pkg::OWNER_W-1:0] i_owner_req,
    output stt_pkg::t_entry           o_entry,
    output logic                      o_expired,
    output logic                      o_match
);
    import stt_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // An entry whose count is zero or one expires on this tick.
    assign o_expired = (r_entry.ticks <= TICKS_W'(1));
    assign o_match   = (r_entry.owner == i_owner_req);
    assign o_entry   = r_entry;

    // Next entry: load, shift in from the right, or count down.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load) begin
            n_entry = i_load_data;
        end else if (i_ctl.shift) begin
            n_entry = i_next;
        end else if (i_ctl.dec) begin
            if (r_entry.ticks != '0) begin
                n_entry.ticks = r_entry.ticks - TICKS_W'(1);
            end
        end
    end

    // Payload only; the table count in the sequencer says which cells hold data.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- rtl/stt_div.sv -----
// Converts milliseconds to ticks at the tick rate with reciprocal multiplications by 1/1000.
`timescale 1ns / 1ps

module stt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [stt_pkg::MS_W-1:0]    i_ms,
    input  logic [stt_pkg::RATE_W-1:0]  i_rate,
    output logic                        o_done,
    output logic [stt_pkg::TICKS_W-1:0] o_ticks
);
    import stt_pkg::*;

    localparam int LAT = 6;

    logic [MS_W-1:0]    r_ms;
    logic [RATE_W-1:0]  r_rate;
    logic [QMS_W-1:0]   r_a;
    logic [REM_W-1:0]   r_b;
    logic [ARATE_W-1:0] r_arate;
    logic [MS_W-1:0]    r_brate;
    logic [QMS_W-1:0]   r_c;
    logic [TICKS_W-1:0] r_q;
    logic [LAT-1:0]     r_vld;

    logic [MS_W-1:0]    w_b_full;

    // Division by 1000 of a value below 2**24 through the reciprocal of 125.
    function automatic logic [QMS_W-1:0] div_1000(input logic [MS_W-1:0] x);
        logic [DPROD_W-1:0] prod;
        prod = DPROD_W'(x[MS_W-1:PRE_SH]) * DPROD_W'(RECIP_125);
        return prod[RECIP_SH +: QMS_W];
    endfunction

    // Progress of the one conversion in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start};
        end
    end

    // Operands are held for the whole conversion.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ms   <= i_ms;
            r_rate <= i_rate;
        end
    end

    // ms = a * 1000 + b, so ms * rate / 1000 = a * rate + b * rate / 1000.
    assign w_b_full = r_ms - (MS_W'(r_a) * MS_W'(MS_PER_S));

    always_ff @(posedge i_clk) begin
        r_a     <= div_1000(r_ms);
        r_b     <= w_b_full[REM_W-1:0];
        r_arate <= ARATE_W'(r_a) * ARATE_W'(r_rate);
        r_brate <= MS_W'(r_b) * MS_W'(r_rate);
        r_c     <= div_1000(r_brate);
        r_q     <= TICKS_W'(r_arate) + TICKS_W'(r_c);
    end

    // The largest count the field ranges allow is below 2**29, so no saturation is needed.
    assign o_done  = r_vld[LAT-1];
    assign o_ticks = r_q;

endmodule

// ----- test/tb_sleep_timer_table_top.sv -----
// Self-checking testbench for the sleep timer table: random and directed words, scored results.
`timescale 1ns / 1ps

module tb_sleep_timer_table_top;

    import stt_pkg::*;

    localparam int MAX_ENTRIES = 16;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int POOL_TOP = 23;

    // One input word and one result word.
    typedef struct packed {
        logic               op;
        logic [OWNER_W-1:0] owner;
        logic [MS_W-1:0]    delay_ms;
    } t_timer_cmd;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [OWNER_W-1:0] owner;
        logic               last;
    } t_timer_event;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_op = 1'b0;
    logic [OWNER_W-1:0]   i_owner_id = '0;
    logic [MS_W-1:0]      i_delay_ms = '0;
    logic                 o_strobe;
    logic [KIND_W-1:0]    o_kind;
    logic [OWNER_W-1:0]   o_owner_out;
    logic                 o_last;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [RATE_W-1:0]    i_cfg_data = '0;

    // Words waiting to be driven and results the table should still produce.
    t_timer_cmd   timer_cmd_q[$];
    t_timer_event timer_events_q[$];

    // Shadow copy of the timer table and the tick rate.
    logic [OWNER_W-1:0] tbl_owner[MAX_ENTRIES];
    logic [TICKS_W-1:0] tbl_ticks[MAX_ENTRIES];
    int                 tbl_count = 0;
    logic [RATE_W-1:0]  rate_hz = 14'd18;

    t_timer_cmd drv_cmd;
    int         gap_cnt = 0;
    bit         gaps_on = 1'b1;
    int         mismatch_cnt = 0;
    int         stall_cycles = 0;

    sleep_timer_table_top #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_op(i_op),
        .i_owner_id(i_owner_id),
        .i_delay_ms(i_delay_ms),
        .o_strobe(o_strobe),
        .o_kind(o_kind),
        .o_owner_out(o_owner_out),
        .o_last(o_last),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Milliseconds to ticks at the current rate, rounded down, saturated at 32 bits.
    function automatic logic [TICKS_W-1:0] delay_to_ticks(input logic [MS_W-1:0] ms);
        logic [63:0] prod;
        prod = (64'(ms) * 64'(rate_hz)) / 64'(MS_PER_S);
        if (prod > 64'hFFFF_FFFF) begin
            prod = 64'hFFFF_FFFF;
        end
        return prod[TICKS_W-1:0];
    endfunction

    // Apply one accepted word to the shadow table and queue the results it causes.
    task automatic timer_table_apply(input t_timer_cmd c);
        t_timer_event ev;
        t_timer_event rel_q[$];
        int idx;
        int keep;
        bit found;
        logic [TICKS_W-1:0] t;
        if (c.op == OP_SET) begin
            found = 1'b0;
            for (idx = 0; idx < tbl_count; idx++) begin
                if (!found && tbl_owner[idx] == c.owner) begin
                    tbl_ticks[idx] = delay_to_ticks(c.delay_ms);
                    found = 1'b1;
                end
            end
            ev.owner = c.owner;
            ev.last = 1'b1;
            ev.kind = KIND_SET;
            if (!found && tbl_count >= MAX_ENTRIES) begin
                ev.kind = KIND_FULL;
            end else if (!found) begin
                tbl_owner[tbl_count] = c.owner;
                tbl_ticks[tbl_count] = delay_to_ticks(c.delay_ms);
                tbl_count++;
            end
            timer_events_q.push_back(ev);
        end else begin
            // Count every entry down; expired ones leave and the rest close up.
            keep = 0;
            for (idx = 0; idx < tbl_count; idx++) begin
                t = tbl_ticks[idx];
                if (t <= 1 && rel_q.size() < MAX_RESULTS) begin
                    ev.kind = KIND_RELEASE;
                    ev.owner = tbl_owner[idx];
                    ev.last = 1'b0;
                    rel_q.push_back(ev);
                end else begin
                    tbl_owner[keep] = tbl_owner[idx];
                    tbl_ticks[keep] = (t == 0) ? '0 : t - 1;
                    keep++;
                end
            end
            tbl_count = keep;
            if (rel_q.size() > 0) begin
                rel_q[rel_q.size() - 1].last = 1'b1;
            end
            foreach (rel_q[idx]) begin
                timer_events_q.push_back(rel_q[idx]);
            end
        end
    endtask

    // Driver: present queued words, hold each until taken, insert idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_cnt <= 0;
        end else if (!start || !busy) begin
            if (start) begin
                timer_table_apply(drv_cmd);
            end
            if (gap_cnt != 0) begin
                gap_cnt <= gap_cnt - 1;
                start <= 1'b0;
            end else if (timer_cmd_q.size() != 0 && gaps_on && $urandom_range(0, 5) == 0) begin
                gap_cnt <= $urandom_range(0, 13);
                start <= 1'b0;
            end else if (timer_cmd_q.size() != 0) begin
                drv_cmd = timer_cmd_q.pop_front();
                start <= 1'b1;
                i_op <= drv_cmd.op;
                i_owner_id <= drv_cmd.owner;
                i_delay_ms <= drv_cmd.delay_ms;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: score every strobed result against the oldest pending one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (timer_events_q.size() == 0) begin
                mismatch_cnt <= mismatch_cnt + 1;
                $display("%0t: unexpected result kind %0d owner %0d last %0d",
                         $time, o_kind, o_owner_out, o_last);
            end else if (timer_events_q[0].kind != o_kind ||
                         timer_events_q[0].owner != o_owner_out ||
                         timer_events_q[0].last != o_last) begin
                mismatch_cnt <= mismatch_cnt + 1;
                $display("%0t: mismatch expected kind %0d owner %0d last %0d",
                         $time, timer_events_q[0].kind, timer_events_q[0].owner,
                         timer_events_q[0].last);
                $display("%0t:          actual   kind %0d owner %0d last %0d",
                         $time, o_kind, o_owner_out, o_last);
                void'(timer_events_q.pop_front());
            end else begin
                void'(timer_events_q.pop_front());
            end
        end
    end

    // Watchdog: count cycles in which no word, result or register write moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        $display("status: fail");
        $finish;
    end

    task automatic queue_cmd(input logic op, input logic [OWNER_W-1:0] owner,
                             input logic [MS_W-1:0] delay_ms);
        t_timer_cmd c;
        c.op = op;
        c.owner = owner;
        c.delay_ms = delay_ms;
        timer_cmd_q.push_back(c);
    endtask

    // Random words: mostly owners from a small pool so refreshes and a full table occur,
    // and delays short enough at the current rate that timers keep expiring.
    task automatic queue_random_cmds(input int n);
        int k;
        int sel;
        int span;
        logic [OWNER_W-1:0] owner;
        logic [MS_W-1:0] delay_ms;
        span = (rate_hz == 0) ? 4000 : 8000 / rate_hz + 1;
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            owner = OWNER_W'($urandom_range(0, POOL_TOP));
            delay_ms = MS_W'($urandom_range(0, span));
            if (sel < 40) begin
                queue_cmd(OP_TICK, OWNER_W'($urandom_range(0, 255)), MS_W'($urandom));
            end else if (sel < 48) begin
                queue_cmd(OP_SET, OWNER_W'($urandom_range(0, 255)), delay_ms);
            end else if (sel < 54) begin
                queue_cmd(OP_SET, owner, MS_W'($urandom));
            end else if (sel < 58) begin
                queue_cmd(OP_SET, owner, ($urandom_range(0, 1) == 1) ? '1 : '0);
            end else begin
                queue_cmd(OP_SET, owner, delay_ms);
            end
        end
    endtask

    // Wait until every word is taken, every result is in and the table is idle.
    task automatic wait_drained();
        while (timer_cmd_q.size() != 0 || start || timer_events_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_tick_rate(input logic [RATE_W-1:0] rate);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= rate;
        do begin
            @(posedge i_clk);
        end while (!(i_cfg_valid && o_cfg_ready));
        rate_hz = rate;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [RATE_W-1:0] rate, input int n);
        wait_drained();
        write_tick_rate(rate);
        queue_random_cmds(n);
    endtask

    // Stimulus sequence: reset, directed cases at the reset rate, then random phases.
    initial begin
        int k;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Tick on an empty table gives nothing; zero delay expires on the next tick.
        queue_cmd(OP_TICK, 8'h00, 24'h000000);
        queue_cmd(OP_SET, 8'h00, 24'h000000);
        queue_cmd(OP_SET, 8'hFF, 24'hFFFFFF);
        queue_cmd(OP_SET, 8'h55, 24'd56);
        queue_cmd(OP_SET, 8'hAA, 24'd200);
        queue_cmd(OP_TICK, 8'hFF, 24'hFFFFFF);
        // Refresh the long timer down to zero so it leaves on the next tick.
        queue_cmd(OP_SET, 8'hFF, 24'h000000);
        queue_cmd(OP_TICK, 8'h00, 24'h000000);
        // Fill the table, overflow it, refresh while full, then release all at once.
        for (k = 0; k < MAX_ENTRIES - 1; k++) begin
            queue_cmd(OP_SET, OWNER_W'(16 + k), 24'h000000);
        end
        queue_cmd(OP_SET, 8'h80, 24'd1000);
        queue_cmd(OP_SET, 8'hAA, 24'h000000);
        queue_cmd(OP_TICK, 8'h00, 24'h000000);

        run_phase(14'd1, 30);
        run_phase(14'h3FFF, 30);
        run_phase(14'd0, 25);
        run_phase(14'($urandom_range(2, 9999)), 30);
        wait_drained();
        gaps_on = 1'b0;
        write_tick_rate(14'd10000);
        queue_random_cmds(35);
        wait_drained();

        if (mismatch_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
